@@ rtl/core/hkf_pkg.sv @@
package hkf_pkg;

    localparam int HELD_DEPTH   = 16;
    localparam int HOTKEY_SLOTS = 7;

    localparam int HELD_AW  = $clog2(HELD_DEPTH);
    localparam int CNT_W    = $clog2(HELD_DEPTH + 1);
    localparam int SLOT_AW  = 3;
    localparam int SLOT_W   = 20;
    localparam int MODK_W   = 48;
    localparam int CFG_IW   = 3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MODKEYS = 3'd0;

    // event opcodes
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_TEXT = 2'd1;

    // result kinds
    localparam logic [1:0] RK_REPLAY = 2'd0;
    localparam logic [1:0] RK_FWD    = 2'd1;
    localparam logic [1:0] RK_HOTKEY = 2'd2;
    localparam logic [1:0] RK_OTHER  = 2'd3;

    // held entry status
    localparam logic [1:0] ST_PENDING   = 2'd0;
    localparam logic [1:0] ST_DELIVERED = 2'd1;
    localparam logic [1:0] ST_CONSUMED  = 2'd2;

    typedef logic [HOTKEY_SLOTS-1:0][SLOT_W-1:0] t_slots;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] scan;
        logic        ext;
        logic [2:0]  mods;
        logic [1:0]  status;
        logic        replay;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [15:0] scan;
        logic        ext;
        logic        prs;
        logic [2:0]  mods;
        logic [2:0]  hk;
        logic [31:0] payload;
        logic        ovf;
    } t_result;

    typedef struct packed {
        logic               hit;
        logic [SLOT_AW-1:0] idx;
        logic               mod_reg;
    } t_match;

    // modifier bit of a key code: control first, then alt, then shift
    function automatic logic [2:0] mod_bit(logic [MODK_W-1:0] mk, logic [15:0] key);
        logic [2:0] b;
        b = 3'b000;
        if (key == mk[15:0]) b = 3'b001;
        else if (key == mk[31:16]) b = 3'b010;
        else if (key == mk[47:32]) b = 3'b100;
        return b;
    endfunction

endpackage

@@ rtl/core/hotkey_key_event_filter.sv @@
// Hotkey key event filter. Key, text and other events arrive one item at a
// time; each item gives zero to HELD_DEPTH+1 result items, the final one
// flagged by o_last_result. Held keys live in a 16-entry single-port-write,
// registered-read table walked by a sequencer. A key item takes a table scan
// and a decide step. Where needed, a flush, consume or compaction pass
// follows, each walking the entries with a read state and a write state.
// Results are pushed from within those passes; a push waits while the
// output path is full. The longest item is the release of the oldest of
// 16 held keys: scan, flush, emit, then compaction.
// Text events flush pending makes first; other events pass at once.
// The input is stalled until the previous item's results have all
// been queued. Results go through a one-deep hold stage (needed to know which
// result is last) and an output register. Configuration is always ready;
// index 0 holds the modifier key codes, 1..7 the hotkey slots.
module hotkey_key_event_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_key_code,
    input  logic [15:0] i_scan_code,
    input  logic        i_extended_flag,
    input  logic        i_pressed,
    input  logic [2:0]  i_modifier_mask,
    input  logic        i_replay_allowed,
    input  logic [31:0] i_passthrough_payload,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [15:0] o_out_key_code,
    output logic [15:0] o_out_scan_code,
    output logic        o_out_extended,
    output logic        o_out_pressed,
    output logic [2:0]  o_out_modifiers,
    output logic [2:0]  o_hotkey_index,
    output logic [31:0] o_out_payload,
    output logic        o_table_overflow,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [hkf_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [hkf_pkg::MODK_W-1:0] i_cfg_data
);
    import hkf_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SCAN   = 11'b00000000010,
        S_DECIDE = 11'b00000000100,
        S_FL_RD  = 11'b00000001000,
        S_FL_WR  = 11'b00000010000,
        S_EMIT   = 11'b00000100000,
        S_CO_RD  = 11'b00001000000,
        S_CO_WR  = 11'b00010000000,
        S_SH_RD  = 11'b00100000000,
        S_SH_WR  = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    // what follows the flush pass
    typedef struct packed {
        logic    emit;
        logic    remove;
        logic    consume;
        t_result res;
    } t_post;

    // configuration
    logic [MODK_W-1:0] r_modkeys;
    t_slots            r_slots;

    // held table
    t_entry             mem [HELD_DEPTH];
    t_entry             rd_data;
    logic [HELD_AW-1:0] mem_ra, mem_wa;
    logic               mem_we;
    t_entry             mem_wd;

    // sequencer
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_dv, n_dv;
    logic               r_found, n_found;
    logic [HELD_AW-1:0] r_fidx, n_fidx;
    t_entry             r_fent, n_fent;
    logic               r_blocked, n_blocked;
    t_post              r_post, n_post;

    // latched item
    logic [15:0] r_key, r_scan;
    logic        r_ext, r_prs, r_rep;
    logic [2:0]  r_mods;

    // result path
    logic    r_hold_v, r_out_v, r_out_last;
    t_result r_hold, r_out;
    logic    push, push_final, out_free, can_emit;
    t_result push_data;

    logic [15:0] key_eff;
    logic [1:0]  st_eff;
    t_match      match;
    t_result     res_fwd;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign out_free    = !r_out_v || !i_stall;
    assign can_emit    = !r_hold_v || out_free;

    assign key_eff = r_found ? r_fent.key : r_key;
    assign st_eff  = r_found ? r_fent.status : ST_PENDING;

    hkf_slot_match u_match (
        .i_slots   (r_slots),
        .i_modkeys (r_modkeys),
        .i_key     (key_eff),
        .i_mods    (r_mods),
        .o_match   (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modkeys <= '0;
            r_slots   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MODKEYS) begin
                r_modkeys <= i_cfg_data;
            end else if ((i_cfg_index - CFG_IW'(1)) < CFG_IW'(HOTKEY_SLOTS)) begin
                r_slots[SLOT_AW'(i_cfg_index - CFG_IW'(1))] <= i_cfg_data[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        rd_data <= mem[mem_ra];
    end

    always_comb begin
        res_fwd         = '0;
        res_fwd.kind    = RK_FWD;
        res_fwd.key     = key_eff;
        res_fwd.scan    = r_scan;
        res_fwd.ext     = r_ext;
        res_fwd.prs     = r_prs;
        res_fwd.mods    = r_mods;
    end

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_dv      = 1'b0;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_fent    = r_fent;
        n_blocked = r_blocked;
        n_post    = r_post;
        mem_ra    = r_ptr[HELD_AW-1:0];
        mem_wa    = r_ptr[HELD_AW-1:0];
        mem_we    = 1'b0;
        mem_wd    = rd_data;
        push      = 1'b0;
        push_final = 1'b0;
        push_data = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ptr          = '0;
                    n_found        = 1'b0;
                    n_blocked      = 1'b0;
                    n_post         = '0;
                    n_post.emit    = 1'b1;
                    n_post.res.kind    = RK_OTHER;
                    n_post.res.payload = i_passthrough_payload;
                    if (i_opcode == OP_KEY) n_state = S_SCAN;
                    else if (i_opcode == OP_TEXT) n_state = S_FL_RD;
                    else n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (r_ptr < r_cnt) begin
                    n_ptr = r_ptr + CNT_W'(1);
                    n_dv  = 1'b1;
                end
                if (r_dv) begin
                    if (!r_found && rd_data.ext == r_ext &&
                            ((rd_data.scan != 16'd0 || r_scan != 16'd0) ?
                             rd_data.scan == r_scan : rd_data.key == r_key)) begin
                        n_found = 1'b1;
                        n_fidx  = HELD_AW'(r_ptr - CNT_W'(1));
                        n_fent  = rd_data;
                    end
                    if (rd_data.status == ST_DELIVERED &&
                            (mod_bit(r_modkeys, rd_data.key) & r_mods) != 3'b000)
                        n_blocked = 1'b1;
                end
                if (r_ptr == r_cnt && !r_dv) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_ptr  = '0;
                n_post = '0;
                n_post.res = res_fwd;
                if (!r_prs) begin
                    if (!r_found) begin
                        n_post.emit = 1'b1;
                        n_state     = S_FL_RD;
                    end else begin
                        n_post.remove = 1'b1;
                        if (r_fent.status != ST_CONSUMED) begin
                            n_post.emit = 1'b1;
                            n_state     = S_FL_RD;
                        end else begin
                            n_ptr   = CNT_W'(r_fidx) + CNT_W'(1);
                            n_state = S_SH_RD;
                        end
                    end
                end else if (!r_found && r_cnt == CNT_W'(HELD_DEPTH)) begin
                    n_post.emit    = 1'b1;
                    n_post.res.ovf = 1'b1;
                    n_state        = S_FL_RD;
                end else begin
                    if (!r_found) begin
                        mem_we        = 1'b1;
                        mem_wa        = r_cnt[HELD_AW-1:0];
                        mem_wd.key    = r_key;
                        mem_wd.scan   = r_scan;
                        mem_wd.ext    = r_ext;
                        mem_wd.mods   = r_mods;
                        mem_wd.status = ST_PENDING;
                        mem_wd.replay = r_rep;
                        n_cnt         = r_cnt + CNT_W'(1);
                    end
                    if (st_eff == ST_DELIVERED) begin
                        n_post.emit = 1'b1;
                        n_state     = S_FL_RD;
                    end else if (!r_blocked && match.hit) begin
                        n_post.emit     = 1'b1;
                        n_post.consume  = 1'b1;
                        n_post.res.kind = RK_HOTKEY;
                        n_post.res.hk   = 3'(match.idx);
                        n_state         = S_EMIT;
                    end else if (st_eff == ST_CONSUMED || match.mod_reg) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FL_RD;
                    end
                end
            end
            S_FL_RD: begin
                if (r_ptr == r_cnt) begin
                    if (r_post.emit) n_state = S_EMIT;
                    else if (r_post.remove) begin
                        n_ptr   = CNT_W'(r_fidx) + CNT_W'(1);
                        n_state = S_SH_RD;
                    end else n_state = S_DONE;
                end else begin
                    n_state = S_FL_WR;
                end
            end
            S_FL_WR: begin
                if (rd_data.status != ST_PENDING) begin
                    n_ptr   = r_ptr + CNT_W'(1);
                    n_state = S_FL_RD;
                end else if (!rd_data.replay || can_emit) begin
                    if (rd_data.replay) begin
                        push           = 1'b1;
                        push_data.kind = RK_REPLAY;
                        push_data.key  = rd_data.key;
                        push_data.scan = rd_data.scan;
                        push_data.ext  = rd_data.ext;
                        push_data.prs  = 1'b1;
                        push_data.mods = rd_data.mods;
                    end
                    mem_we        = 1'b1;
                    mem_wd.status = ST_DELIVERED;
                    n_ptr         = r_ptr + CNT_W'(1);
                    n_state       = S_FL_RD;
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    push      = 1'b1;
                    push_data = r_post.res;
                    if (r_post.consume) begin
                        n_ptr   = '0;
                        n_state = S_CO_RD;
                    end else if (r_post.remove) begin
                        n_ptr   = CNT_W'(r_fidx) + CNT_W'(1);
                        n_state = S_SH_RD;
                    end else n_state = S_DONE;
                end
            end
            S_CO_RD: begin
                n_state = (r_ptr == r_cnt) ? S_DONE : S_CO_WR;
            end
            S_CO_WR: begin
                if (rd_data.status == ST_PENDING) begin
                    mem_we        = 1'b1;
                    mem_wd.status = ST_CONSUMED;
                end
                n_ptr   = r_ptr + CNT_W'(1);
                n_state = S_CO_RD;
            end
            S_SH_RD: begin
                if (r_ptr == r_cnt) begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_DONE;
                end else n_state = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we  = 1'b1;
                mem_wa  = HELD_AW'(r_ptr - CNT_W'(1));
                n_ptr   = r_ptr + CNT_W'(1);
                n_state = S_SH_RD;
            end
            S_DONE: begin
                if (!r_hold_v) n_state = S_IDLE;
                else if (out_free) begin
                    push_final = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dv    <= n_dv;
        end
        r_ptr     <= n_ptr;
        r_found   <= n_found;
        r_fidx    <= n_fidx;
        r_fent    <= n_fent;
        r_blocked <= n_blocked;
        r_post    <= n_post;
        if (r_state == S_IDLE && i_valid) begin
            r_key  <= i_key_code;
            r_scan <= i_scan_code;
            r_ext  <= i_extended_flag;
            r_prs  <= i_pressed;
            r_mods <= i_modifier_mask;
            r_rep  <= i_replay_allowed;
        end
    end

    // hold stage: a result moves on only once the next one, or the end of
    // the item, says whether it is last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (push) begin
            if (r_hold_v) begin
                r_out      <= r_hold;
                r_out_last <= 1'b0;
                r_out_v    <= 1'b1;
            end else if (out_free) begin
                r_out_v <= 1'b0;
            end
            r_hold   <= push_data;
            r_hold_v <= 1'b1;
        end else if (push_final) begin
            r_out      <= r_hold;
            r_out_last <= 1'b1;
            r_out_v    <= 1'b1;
            r_hold_v   <= 1'b0;
        end else if (out_free) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid          = r_out_v;
    assign o_result_kind    = r_out.kind;
    assign o_out_key_code   = r_out.key;
    assign o_out_scan_code  = r_out.scan;
    assign o_out_extended   = r_out.ext;
    assign o_out_pressed    = r_out.prs;
    assign o_out_modifiers  = r_out.mods;
    assign o_hotkey_index   = r_out.hk;
    assign o_out_payload    = r_out.payload;
    assign o_table_overflow = r_out.ovf;
    assign o_last_result    = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HELD_DEPTH))
        else $error("held count beyond table depth");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_v)
        else $error("result left in hold stage while idle");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FL_WR || r_state == S_CO_WR) |-> r_ptr < r_cnt)
        else $error("table walk past held count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> can_emit)
        else $error("result pushed with no room");

endmodule

@@ rtl/core/hkf_slot_match.sv @@
module hkf_slot_match (
    input  hkf_pkg::t_slots               i_slots,
    input  logic [hkf_pkg::MODK_W-1:0]    i_modkeys,
    input  logic [15:0]                   i_key,
    input  logic [2:0]                    i_mods,
    output hkf_pkg::t_match               o_match
);
    import hkf_pkg::*;

    logic [2:0] kbit;

    always_comb begin
        kbit = mod_bit(i_modkeys, i_key);
        o_match = '0;
        // walk down so the lowest matching slot wins
        for (int s = HOTKEY_SLOTS - 1; s >= 0; s--) begin
            if (i_slots[s][19] && i_slots[s][15:0] == i_key
                    && i_slots[s][18:16] == i_mods) begin
                o_match.hit = 1'b1;
                o_match.idx = SLOT_AW'(s);
            end
            if (i_slots[s][19] && (i_slots[s][18:16] & kbit) != 3'b000)
                o_match.mod_reg = 1'b1;
        end
    end

endmodule

@@ dv/tb_hotkey_key_event_filter.sv @@
module tb_hotkey_key_event_filter;
    import hkf_pkg::*;

    // Result item as seen on the output port; last flag included.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] key;
        logic [15:0] scan;
        logic        ext;
        logic        prs;
        logic [2:0]  mods;
        logic [2:0]  hk;
        logic [31:0] payload;
        logic        ovf;
        logic        last;
    } t_exp;

    // Other-event opcode, and opcode three which behaves the same.
    localparam logic [1:0] OP_OTHER = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Register indexes beyond the modifier key word.
    localparam logic [CFG_IW-1:0] CFG_SLOT0 = 3'd1;

    localparam int DRAIN_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [15:0] i_key_code;
    logic [15:0] i_scan_code;
    logic        i_extended_flag;
    logic        i_pressed;
    logic [2:0]  i_modifier_mask;
    logic        i_replay_allowed;
    logic [31:0] i_passthrough_payload;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_result_kind;
    logic [15:0] o_out_key_code;
    logic [15:0] o_out_scan_code;
    logic        o_out_extended;
    logic        o_out_pressed;
    logic [2:0]  o_out_modifiers;
    logic [2:0]  o_hotkey_index;
    logic [31:0] o_out_payload;
    logic        o_table_overflow;
    logic        o_last_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [MODK_W-1:0] i_cfg_data;

    hotkey_key_event_filter u_top (.*);

    // Shadow copy of the block's configuration and held-key table.
    logic [MODK_W-1:0] mod_codes;
    logic [SLOT_W-1:0] hk_slots [HOTKEY_SLOTS];
    t_entry            held [HELD_DEPTH];
    int                held_n;

    t_exp expected_results [$];
    int   fail_count;
    int   send_idle_pct;
    int   recv_stall_pct;

    // Random key pool kept small so presses and releases meet each other.
    logic [15:0] pool_key [8];
    logic [15:0] pool_scan [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb_hotkey_key_event_filter NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [2:0] modkey_bit(logic [15:0] key);
        if (key == mod_codes[15:0]) return 3'b001;
        if (key == mod_codes[31:16]) return 3'b010;
        if (key == mod_codes[47:32]) return 3'b100;
        return 3'b000;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [15:0] key,
            logic [15:0] scan, logic ext, logic prs, logic [2:0] mods,
            logic [2:0] hk, logic [31:0] payload, logic ovf);
        t_exp r;
        r = '{kind, key, scan, ext, prs, mods, hk, payload, ovf, 1'b0};
        expected_results.push_back(r);
    endfunction

    // Pending makes go out in press order; refused replays are just delivered.
    function automatic void flush_pending_makes();
        for (int i = 0; i < held_n; i++) begin
            if (held[i].status == ST_PENDING) begin
                if (held[i].replay)
                    push_result(RK_REPLAY, held[i].key, held[i].scan, held[i].ext, 1'b1,
                                held[i].mods, 3'd0, 32'd0, 1'b0);
                held[i].status = ST_DELIVERED;
            end
        end
    endfunction

    function automatic void predict_event(logic [1:0] op, logic [15:0] key_in,
            logic [15:0] scan, logic ext, logic prs, logic [2:0] mods, logic rep,
            logic [31:0] payload);
        int   start_len;
        int   idx;
        int   hk;
        logic eligible;
        logic [15:0] key;
        logic [2:0]  mbit;
        logic        registered;
        start_len = expected_results.size();
        key = key_in;
        eligible = 1'b1;
        hk = -1;
        if (op != OP_KEY) begin
            if (op == OP_TEXT) flush_pending_makes();
            push_result(RK_OTHER, 16'd0, 16'd0, 1'b0, 1'b0, 3'd0, 3'd0, payload, 1'b0);
        end else begin
            idx = held_n;
            for (int i = 0; i < held_n; i++) begin
                if (held[i].ext == ext && idx == held_n) begin
                    if (held[i].scan != 16'd0 || scan != 16'd0) begin
                        if (held[i].scan == scan) idx = i;
                    end else if (held[i].key == key) begin
                        idx = i;
                    end
                end
            end
            if (idx < held_n) key = held[idx].key;
            if (!prs) begin
                if (idx == held_n || held[idx].status != ST_CONSUMED) begin
                    flush_pending_makes();
                    push_result(RK_FWD, key, scan, ext, 1'b0, mods, 3'd0, 32'd0, 1'b0);
                end
                if (idx < held_n) begin
                    for (int i = idx; i + 1 < held_n; i++) held[i] = held[i + 1];
                    held_n--;
                end
            end else if (idx == held_n && held_n >= HELD_DEPTH) begin
                flush_pending_makes();
                push_result(RK_FWD, key, scan, ext, 1'b1, mods, 3'd0, 32'd0, 1'b1);
            end else begin
                if (idx == held_n) begin
                    held[idx] = '{key, scan, ext, mods, ST_PENDING, rep};
                    held_n++;
                end
                if (held[idx].status == ST_DELIVERED) begin
                    flush_pending_makes();
                    push_result(RK_FWD, key, scan, ext, 1'b1, mods, 3'd0, 32'd0, 1'b0);
                end else begin
                    // A delivered modifier key named in the mask blocks hotkeys.
                    for (int i = 0; i < held_n; i++)
                        if (held[i].status == ST_DELIVERED &&
                            (modkey_bit(held[i].key) & mods) != 3'd0) eligible = 1'b0;
                    if (eligible)
                        for (int s = HOTKEY_SLOTS - 1; s >= 0; s--)
                            if (hk_slots[s][19] && hk_slots[s][15:0] == key &&
                                hk_slots[s][18:16] == mods) hk = s;
                    if (hk >= 0) begin
                        for (int i = 0; i < held_n; i++)
                            if (held[i].status == ST_PENDING) held[i].status = ST_CONSUMED;
                        push_result(RK_HOTKEY, key, scan, ext, 1'b1, mods, 3'(hk),
                                    32'd0, 1'b0);
                    end else if (held[idx].status != ST_CONSUMED) begin
                        mbit = modkey_bit(key);
                        registered = 1'b0;
                        for (int s = 0; s < HOTKEY_SLOTS; s++)
                            if (mbit != 3'd0 && hk_slots[s][19] &&
                                (hk_slots[s][18:16] & mbit) != 3'd0) registered = 1'b1;
                        if (!registered) flush_pending_makes();
                    end
                end
            end
        end
        if (expected_results.size() > start_len)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_event(logic [1:0] op, logic [15:0] key, logic [15:0] scan,
            logic ext, logic prs, logic [2:0] mods, logic rep, logic [31:0] payload);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid               <= 1'b1;
        i_opcode              <= op;
        i_key_code            <= key;
        i_scan_code           <= scan;
        i_extended_flag       <= ext;
        i_pressed             <= prs;
        i_modifier_mask       <= mods;
        i_replay_allowed      <= rep;
        i_passthrough_payload <= payload;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_event(op, key, scan, ext, prs, mods, rep, payload);
        i_valid <= 1'b0;
        // the block is busy right after an accept, so this gap costs nothing
        @(posedge i_clk);
    endtask

    // Waits for every result, plus the block's worst-case tail for items
    // that give none, so the block is idle afterwards.
    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] index, logic [MODK_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == CFG_MODKEYS) mod_codes = value;
        else hk_slots[index - CFG_SLOT0] = value[SLOT_W-1:0];
        @(posedge i_clk);
    endtask

    // Output side: random stall, compare each accepted result.
    always @(posedge i_clk) begin
        t_exp e;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with none expected: kind %0d key %h",
                           o_result_kind, o_out_key_code);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_result_kind !== e.kind) begin
                        $error("result_kind exp %0d got %0d", e.kind, o_result_kind);
                        fail_count++;
                    end
                    if (o_out_key_code !== e.key) begin
                        $error("out_key_code exp %h got %h", e.key, o_out_key_code);
                        fail_count++;
                    end
                    if (o_out_scan_code !== e.scan) begin
                        $error("out_scan_code exp %h got %h", e.scan, o_out_scan_code);
                        fail_count++;
                    end
                    if (o_out_extended !== e.ext) begin
                        $error("out_extended exp %0d got %0d", e.ext, o_out_extended);
                        fail_count++;
                    end
                    if (o_out_pressed !== e.prs) begin
                        $error("out_pressed exp %0d got %0d", e.prs, o_out_pressed);
                        fail_count++;
                    end
                    if (o_out_modifiers !== e.mods) begin
                        $error("out_modifiers exp %0d got %0d", e.mods, o_out_modifiers);
                        fail_count++;
                    end
                    if (o_hotkey_index !== e.hk) begin
                        $error("hotkey_index exp %0d got %0d", e.hk, o_hotkey_index);
                        fail_count++;
                    end
                    if (o_out_payload !== e.payload) begin
                        $error("out_payload exp %h got %h", e.payload, o_out_payload);
                        fail_count++;
                    end
                    if (o_table_overflow !== e.ovf) begin
                        $error("table_overflow exp %0d got %0d", e.ovf, o_table_overflow);
                        fail_count++;
                    end
                    if (o_last_result !== e.last) begin
                        $error("last_result exp %0d got %0d", e.last, o_last_result);
                        fail_count++;
                    end
                end
            end
            i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Modifier keys 0x11/0x12/0x10; hotkeys on 0x41 with ctrl, 0x42 ctrl+alt.
    task automatic test_config_basic();
        write_reg(CFG_MODKEYS, 48'h0010_0012_0011);
        write_reg(CFG_SLOT0 + 0, {1'b1, 3'b001, 16'h0041});
        write_reg(CFG_SLOT0 + 1, {1'b1, 3'b011, 16'h0042});
        write_reg(CFG_SLOT0 + 2, {1'b1, 3'b001, 16'h0041}); // duplicate: slot 0 wins
        write_reg(CFG_SLOT0 + 3, {1'b0, 3'b111, 16'hFFFF}); // invalid slot
        write_reg(CFG_SLOT0 + 4, {1'b1, 3'b100, 16'hFFFF});
        write_reg(CFG_SLOT0 + 5, {1'b1, 3'b000, 16'h0000});
        write_reg(CFG_SLOT0 + 6, {1'b1, 3'b111, 16'h0043});
    endtask

    task automatic test_directed();
        // ctrl held (registered, withheld), then ctrl+A gives hotkey, releases
        send_event(OP_KEY, 16'h0011, 16'h001D, 1'b0, 1'b1, 3'b001, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0041, 16'h001E, 1'b0, 1'b1, 3'b001, 1'b1, 32'd0);
        // repeat of consumed key, no match: nothing
        send_event(OP_KEY, 16'h0041, 16'h001E, 1'b0, 1'b1, 3'b000, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0041, 16'h001E, 1'b0, 1'b0, 3'b001, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0011, 16'h001D, 1'b0, 1'b0, 3'b000, 1'b1, 32'd0);
        // held key code: same scan, other key code
        send_event(OP_KEY, 16'h0058, 16'h002D, 1'b1, 1'b1, 3'b000, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h1234, 16'h002D, 1'b1, 1'b1, 3'b000, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h9999, 16'h002D, 1'b1, 1'b0, 3'b000, 1'b1, 32'd0);
        // scan zero matched by key code; replay refused
        send_event(OP_KEY, 16'h0011, 16'h0000, 1'b0, 1'b1, 3'b001, 1'b0, 32'd0);
        send_event(OP_TEXT, 16'h0, 16'h0, 1'b0, 1'b0, 3'b0, 1'b0, 32'hFFFF_FFFF);
        // delivered ctrl blocks hotkey
        send_event(OP_KEY, 16'h0041, 16'h001E, 1'b0, 1'b1, 3'b001, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0041, 16'h001E, 1'b0, 1'b0, 3'b001, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0011, 16'h0000, 1'b0, 1'b0, 3'b000, 1'b1, 32'd0);
        // release of untracked key, other and spare opcodes
        send_event(OP_KEY, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 3'b111, 1'b1, 32'd0);
        send_event(OP_OTHER, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 3'b111, 1'b1, 32'h0);
        send_event(OP_SPARE, 16'h0, 16'h0, 1'b0, 1'b0, 3'b0, 1'b0, 32'hA5A5_5A5A);
        // lowest-index slot with key zero, mods zero
        send_event(OP_KEY, 16'h0000, 16'h0000, 1'b0, 1'b1, 3'b000, 1'b1, 32'd0);
        send_event(OP_KEY, 16'h0000, 16'h0000, 1'b0, 1'b0, 3'b000, 1'b1, 32'd0);
        wait_idle();
    endtask

    // Fill the table, overflow, then release everything.
    task automatic test_table_full();
        for (int i = 0; i < HELD_DEPTH + 2; i++)
            send_event(OP_KEY, 16'h0011, 16'(16'h100 + i), 1'b0, 1'b1, 3'b001, 1'(i & 1),
                       32'd0);
        send_event(OP_TEXT, 16'h0, 16'h0, 1'b0, 1'b0, 3'b0, 1'b0, 32'h1);
        for (int i = 0; i < HELD_DEPTH + 2; i++)
            send_event(OP_KEY, 16'h0011, 16'(16'h100 + i), 1'b0, 1'b0, 3'b000, 1'b1, 32'd0);
        wait_idle();
    endtask

    function automatic void new_key_pool();
        for (int i = 0; i < 8; i++) begin
            pool_key[i]  = (i < 3) ? mod_codes[16*i +: 16] :
                           (i < 6) ? hk_slots[i - 3][15:0] : 16'($urandom);
            pool_scan[i] = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom);
        end
    endfunction

    task automatic random_events(int count);
        int          k;
        int          r;
        logic [2:0]  m;
        new_key_pool();
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(7);
            r = $urandom_range(99);
            m = ($urandom_range(1)) ? hk_slots[$urandom_range(HOTKEY_SLOTS - 1)][18:16]
                                    : 3'($urandom);
            if (r < 6)
                send_event(2'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                           1'($urandom), 3'($urandom), 1'($urandom), $urandom);
            else if (r < 16)
                send_event(2'($urandom_range(1, 3)), 16'd0, 16'd0, 1'b0, 1'b0, 3'd0, 1'b0,
                           $urandom);
            else
                send_event(OP_KEY, pool_key[k], pool_scan[k], 1'(k == 7 && $urandom),
                           ($urandom_range(99) < 60), m, ($urandom_range(3) != 0), 32'd0);
            if (n == count / 2) begin
                // hold off until everything has drained
                while (expected_results.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_random_config();
        write_reg(CFG_MODKEYS, {16'($urandom), 16'($urandom), 16'($urandom)});
        for (int s = 0; s < HOTKEY_SLOTS; s++)
            write_reg(CFG_SLOT0 + 3'(s), {1'($urandom_range(3) != 0), 3'($urandom),
                                          16'($urandom)});
    endtask

    initial begin
        fail_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        held_n         = 0;
        mod_codes      = '0;
        for (int s = 0; s < HOTKEY_SLOTS; s++) hk_slots[s] = '0;
        i_rst_n               = 1'b0;
        i_valid               = 1'b0;
        i_stall               = 1'b0;
        i_opcode              = OP_KEY;
        i_key_code            = '0;
        i_scan_code           = '0;
        i_extended_flag       = 1'b0;
        i_pressed             = 1'b0;
        i_modifier_mask       = '0;
        i_replay_allowed      = 1'b0;
        i_passthrough_payload = '0;
        i_cfg_valid           = 1'b0;
        i_cfg_index           = CFG_MODKEYS;
        i_cfg_data            = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_config_basic();
        test_directed();
        send_idle_pct  = 60;
        test_table_full();

        // Random phases: none, sender idle, receiver stall, both light.
        send_idle_pct = 0;  recv_stall_pct = 0;  random_events(40);
        send_idle_pct = 60; recv_stall_pct = 0;  random_events(30);
        wait_idle();
        test_random_config();
        send_idle_pct = 0;  recv_stall_pct = 60; random_events(30);
        wait_idle();
        write_reg(CFG_MODKEYS, {MODK_W{1'b1}});
        write_reg(CFG_SLOT0 + 6, {SLOT_W{1'b1}});
        test_config_basic();
        send_idle_pct = 13; recv_stall_pct = 13; random_events(55);

        wait_idle();
        if (fail_count == 0) begin
            $display("tb_hotkey_key_event_filter OK");
        end else begin
            $display("tb_hotkey_key_event_filter NOT OK");
        end
        $finish;
    end

endmodule
